### rtl/core/kabf_pkg.sv
// Shared types, constants and helpers for the angle/bias Kalman filter.
// No dependencies.
package kabf_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int COV_FRAC_BITS   = 24;
   localparam int DT_FRAC_BITS    = 16;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] CSR_MEAS_NOISE  = 2'd2;

   localparam logic [31:0] ANGLE_NOISE_RST = 32'd16777;
   localparam logic [31:0] BIAS_NOISE_RST  = 32'd50332;
   localparam logic [31:0] MEAS_NOISE_RST  = 32'd503316;

   typedef struct packed {
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
      logic        [15:0] time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] bias_estimate;
      logic signed [31:0] unbiased_rate;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [55:0] num;
      logic signed [33:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quo;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

### rtl/core/kabf_mac.sv
// Shared signed multiplier with registered product and round-half-up rescale.
// Depends on kabf_pkg.
module kabf_mac (
   input  logic               clock,
   input  logic signed [35:0] mul_a,
   input  logic signed [32:0] mul_b,
   input  logic               shift_long,
   output logic signed [55:0] mul_res
);
   import kabf_pkg::*;

   logic signed [68:0] prod_ff;
   logic signed [68:0] prod_in;
   logic               long_ff;
   logic signed [69:0] sum;
   logic signed [69:0] shifted;

   assign prod_in = 69'(mul_a) * 69'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      long_ff <= shift_long;
   end

   // round half up: add half an lsb, then floor shift
   always_comb begin
      if (long_ff) begin
         sum     = 70'(prod_ff) + (70'sd1 <<< (COV_FRAC_BITS - 1));
         shifted = sum >>> COV_FRAC_BITS;
      end else begin
         sum     = 70'(prod_ff) + (70'sd1 <<< (DT_FRAC_BITS - 1));
         shifted = sum >>> DT_FRAC_BITS;
      end
   end

   assign mul_res = shifted[55:0];

endmodule

### rtl/core/kabf_div.sv
// Radix-2 restoring divider for the gains: truncates toward zero, saturates.
// Depends on kabf_pkg.
module kabf_div (
   input  logic        clock,
   input  logic        reset,
   input  kabf_pkg::div_req_type div_req,
   output kabf_pkg::div_rsp_type div_rsp
);
   import kabf_pkg::*;

   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [5:0]  cnt_ff,   cnt_in;
   logic [34:0] rem_ff,   rem_in;
   logic [55:0] quo_ff,   quo_in;
   logic [33:0] den_ff,   den_in;
   logic        neg_ff,   neg_in;
   logic        zero_ff,  zero_in;
   logic [34:0] trial;
   logic [35:0] diff;
   logic [55:0] nmag;
   logic [33:0] dmag;
   logic signed [63:0] qs;

   always_comb begin
      nmag    = div_req.num[55] ? 56'(-div_req.num) : div_req.num;
      dmag    = div_req.den[33] ? 34'(-div_req.den) : div_req.den;
      trial   = {rem_ff[33:0], quo_ff[55]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd55;
         rem_in  = '0;
         quo_in  = nmag;
         den_in  = dmag;
         neg_in  = div_req.num[55] ^ div_req.den[33];
         zero_in = (div_req.den == '0);
      end else if (busy_ff) begin
         // shift one dividend bit in, keep the difference when it fits
         if (!diff[35]) begin
            rem_in = diff[34:0];
            quo_in = {quo_ff[54:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[54:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      qs = neg_ff ? -$signed({8'd0, quo_ff}) : $signed({8'd0, quo_ff});
      div_rsp.done = done_ff;
      div_rsp.quo  = zero_ff ? '0 : sat32(qs);
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !div_req.start) else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");

endmodule

### rtl/core/kalman_angle_bias_filter_top.sv
// Top level of the two-state (angle, gyro bias) Kalman filter.
// Depends on kabf_pkg, kabf_mac and kabf_div.
//
// Usage:
//  - Input channel req_*: one beat carries measured angle (Q16.16), gyro
//    rate (Q16.16) and time step (Q0.16). A beat is taken when req_valid is
//    high and req_stall low. req_stall is low only while the filter is idle.
//  - Result channel rsp_*: one beat per input beat with the corrected angle,
//    the bias estimate and the unbiased rate, all Q16.16 and saturated.
//  - csr_*: APB-style port, three noise registers at byte addresses 0, 4
//    and 8. pready is always high; write only while the filter is idle.
//  - Each item runs through one shared multiplier (ten products, each issued
//    in S_MUL and written back in S_WB) and one bit-serial divider (two
//    gains, one after the other), plus a preparation state S_PREP. The filter
//    takes no new beat until the result beat has been taken and it is back
//    in the idle state.
//  - A finished result is held in rsp_valid until the receiver takes it;
//    while rsp_stall is high, the result and the filter state hold and no new beat
//    is accepted. After the result beat the filter is idle again.
//  - Reset clears the state estimate and the whole covariance matrix and
//    loads the default noise values.
module kalman_angle_bias_filter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kabf_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kabf_pkg::rsp_type   rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [kabf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import kabf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_WB, S_PREP, S_DIV, S_OUT
   } state_type;

   // product steps, in issue order
   localparam logic [3:0] ST_ANGLE_PRED = 4'd0;
   localparam logic [3:0] ST_DT_P11     = 4'd1;
   localparam logic [3:0] ST_P00_PRED   = 4'd2;
   localparam logic [3:0] ST_P11_PRED   = 4'd3;
   localparam logic [3:0] ST_ANGLE_CORR = 4'd4;
   localparam logic [3:0] ST_BIAS_CORR  = 4'd5;
   localparam logic [3:0] ST_P00_CORR   = 4'd6;
   localparam logic [3:0] ST_P01_CORR   = 4'd7;
   localparam logic [3:0] ST_P10_CORR   = 4'd8;
   localparam logic [3:0] ST_P11_CORR   = 4'd9;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       sel_ff,  sel_in;

   logic [31:0] qa_ff, qa_in, qb_ff, qb_in, rn_ff, rn_in;

   logic signed [31:0] meas_ff, meas_in;
   logic        [15:0] dt_ff,   dt_in;
   logic signed [31:0] rate_ff, rate_in;
   logic signed [31:0] ang_ff,  ang_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [31:0] p00_ff,  p00_in;
   logic signed [31:0] p01_ff,  p01_in;
   logic signed [31:0] p10_ff,  p10_in;
   logic signed [31:0] p11_ff,  p11_in;
   logic signed [33:0] dtp11_ff, dtp11_in;
   logic signed [31:0] y_ff,    y_in;
   logic signed [31:0] k0_ff,   k0_in;
   logic signed [31:0] k1_ff,   k1_in;
   logic signed [31:0] p00s_ff, p00s_in;
   logic signed [31:0] p01s_ff, p01s_in;

   logic signed [35:0] mul_a;
   logic signed [32:0] mul_b;
   logic               shift_long;
   logic signed [55:0] mul_res;
   logic signed [35:0] inner;
   logic signed [33:0] s_sum;
   logic signed [32:0] dt_s;
   logic               accept;
   logic               csr_wr;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   kabf_mac u_mac (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .shift_long (shift_long),
      .mul_res    (mul_res)
   );

   kabf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   assign rsp_data.filtered_angle = ang_ff;
   assign rsp_data.bias_estimate  = bias_ff;
   assign rsp_data.unbiased_rate  = rate_ff;

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_ANGLE_NOISE: csr_prdata = qa_ff;
         CSR_BIAS_NOISE:  csr_prdata = qb_ff;
         CSR_MEAS_NOISE:  csr_prdata = rn_ff;
         default:         csr_prdata = '0;
      endcase
   end

   assign dt_s  = $signed({17'd0, dt_ff});
   assign inner = 36'(dtp11_ff) - 36'(p01_ff) - 36'(p10_ff) + $signed({4'd0, qa_ff});
   // innovation variance; stays put while the gains are divided out
   assign s_sum = 34'(p00_ff) + $signed({2'd0, rn_ff});

   // operand selection for the shared multiplier
   always_comb begin
      shift_long = 1'b1;
      unique case (step_ff)
         ST_ANGLE_PRED: begin mul_a = 36'(rate_ff); mul_b = dt_s; shift_long = 1'b0; end
         ST_DT_P11:     begin mul_a = 36'(p11_ff);  mul_b = dt_s; shift_long = 1'b0; end
         ST_P00_PRED:   begin mul_a = inner;        mul_b = dt_s; shift_long = 1'b0; end
         ST_P11_PRED:   begin
            mul_a = $signed({4'd0, qb_ff}); mul_b = dt_s; shift_long = 1'b0;
         end
         ST_ANGLE_CORR: begin mul_a = 36'(k0_ff); mul_b = 33'(y_ff);    end
         ST_BIAS_CORR:  begin mul_a = 36'(k1_ff); mul_b = 33'(y_ff);    end
         ST_P00_CORR:   begin mul_a = 36'(k0_ff); mul_b = 33'(p00s_ff); end
         ST_P01_CORR:   begin mul_a = 36'(k0_ff); mul_b = 33'(p01s_ff); end
         ST_P10_CORR:   begin mul_a = 36'(k1_ff); mul_b = 33'(p00s_ff); end
         ST_P11_CORR:   begin mul_a = 36'(k1_ff); mul_b = 33'(p01s_ff); end
         default:       begin mul_a = '0;         mul_b = '0;           end
      endcase
   end

   // start the first gain from the prep cycle, the second as the first lands
   always_comb begin
      div_req.start = (state_ff == S_PREP) ||
                      (state_ff == S_DIV && div_rsp.done && !sel_ff);
      div_req.num   = (state_ff == S_PREP) ? (56'(p00_ff) <<< COV_FRAC_BITS)
                                           : (56'(p10_ff) <<< COV_FRAC_BITS);
      div_req.den   = s_sum;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sel_in   = sel_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      rn_in    = rn_ff;
      meas_in  = meas_ff;
      dt_in    = dt_ff;
      rate_in  = rate_ff;
      ang_in   = ang_ff;
      bias_in  = bias_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;
      dtp11_in = dtp11_ff;
      y_in     = y_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      p00s_in  = p00s_ff;
      p01s_in  = p01s_ff;

      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_ANGLE_NOISE: qa_in = csr_pwdata;
            CSR_BIAS_NOISE:  qb_in = csr_pwdata;
            CSR_MEAS_NOISE:  rn_in = csr_pwdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               meas_in  = req_data.measured_angle;
               dt_in    = req_data.time_step;
               rate_in  = sat32(64'(req_data.gyro_rate) - 64'(bias_ff));
               step_in  = ST_ANGLE_PRED;
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_WB;
         S_WB: begin
            state_in = S_MUL;
            step_in  = step_ff + 4'd1;
            unique case (step_ff)
               ST_ANGLE_PRED: ang_in   = sat32(64'(ang_ff) + 64'(mul_res));
               ST_DT_P11:     dtp11_in = mul_res[33:0];
               ST_P00_PRED: begin
                  p00_in = sat32(64'(p00_ff) + 64'(mul_res));
                  p01_in = sat32(64'(p01_ff) - 64'(dtp11_ff));
                  p10_in = sat32(64'(p10_ff) - 64'(dtp11_ff));
               end
               ST_P11_PRED: begin
                  p11_in   = sat32(64'(p11_ff) + 64'(mul_res));
                  state_in = S_PREP;
               end
               ST_ANGLE_CORR: ang_in  = sat32(64'(ang_ff) + 64'(mul_res));
               ST_BIAS_CORR:  bias_in = sat32(64'(bias_ff) + 64'(mul_res));
               ST_P00_CORR:   p00_in  = sat32(64'(p00_ff) - 64'(mul_res));
               ST_P01_CORR:   p01_in  = sat32(64'(p01_ff) - 64'(mul_res));
               ST_P10_CORR:   p10_in  = sat32(64'(p10_ff) - 64'(mul_res));
               ST_P11_CORR: begin
                  p11_in   = sat32(64'(p11_ff) - 64'(mul_res));
                  state_in = S_OUT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PREP: begin
            // capture the predicted terms the correction reads
            y_in     = sat32(64'(meas_ff) - 64'(ang_ff));
            p00s_in  = p00_ff;
            p01s_in  = p01_ff;
            sel_in   = 1'b0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (!sel_ff) begin
                  k0_in  = div_rsp.quo;
                  sel_in = 1'b1;
               end else begin
                  k1_in    = div_rsp.quo;
                  step_in  = ST_ANGLE_CORR;
                  state_in = S_MUL;
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= ST_ANGLE_PRED;
         sel_ff   <= 1'b0;
         qa_ff    <= ANGLE_NOISE_RST;
         qb_ff    <= BIAS_NOISE_RST;
         rn_ff    <= MEAS_NOISE_RST;
         ang_ff   <= '0;
         bias_ff  <= '0;
         p00_ff   <= '0;
         p01_ff   <= '0;
         p10_ff   <= '0;
         p11_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
         qa_ff    <= qa_in;
         qb_ff    <= qb_in;
         rn_ff    <= rn_in;
         ang_ff   <= ang_in;
         bias_ff  <= bias_in;
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
      end
      meas_ff  <= meas_in;
      dt_ff    <= dt_in;
      rate_ff  <= rate_in;
      dtp11_ff <= dtp11_in;
      y_ff     <= y_in;
      k0_ff    <= k0_in;
      k1_ff    <= k1_in;
      p00s_ff  <= p00s_in;
      p01s_ff  <= p01s_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall) else $error("beat accepted while busy");
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid) else $error("result repeated");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV) else $error("gain landed outside divide");
   a_out_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_ff) == ST_P11_CORR)
      else $error("result raised before last update");

endmodule

### verif/tb_top.sv
// Self-checking bench for the angle/bias Kalman filter top level.
// Depends on kabf_pkg and the filter RTL; a scoreboard class predicts each result.
module tb_top;
   import kabf_pkg::*;

   localparam int IDLE_PCT  = 38;
   localparam int N_RANDOM  = 1650;
   localparam int WD_LIMIT  = 20000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // Predictor of the filter, with its own copy of state and noise settings.
   class filter_scoreboard;
      logic [31:0] q_angle, q_bias, r_meas;
      longint ang, bia, p00, p01, p10, p11;
      rsp_type pending[$];
      int errors;
      int checked;

      function new();
         errors = 0;
         checked = 0;
         clear();
      endfunction

      function void clear();
         q_angle = ANGLE_NOISE_RST;
         q_bias  = BIAS_NOISE_RST;
         r_meas  = MEAS_NOISE_RST;
         ang = 0; bia = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      endfunction

      function void set_noise(int idx, logic [31:0] v);
         if (idx == CSR_ANGLE_NOISE) q_angle = v;
         else if (idx == CSR_BIAS_NOISE) q_bias = v;
         else if (idx == CSR_MEAS_NOISE) r_meas = v;
      endfunction

      function longint clip(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // round half up: floor((v + half) / 2^s); >>> is floor on signed values
      function longint rnd(longint v, int s);
         longint t;
         t = v + (longint'(1) << (s - 1));
         return t >>> s;
      endfunction

      function longint kgain(longint num, longint den);
         if (den == 0) return 0;
         return clip((num * (longint'(1) << COV_FRAC_BITS)) / den);
      endfunction

      function void note_input(req_type r);
         longint meas, gyro, dt, rate, dtp, inner, y, s, k0, k1, a0, a1;
         rsp_type e;
         meas = longint'(r.measured_angle);
         gyro = longint'(r.gyro_rate);
         dt   = longint'({48'd0, r.time_step});
         rate = clip(gyro - bia);
         ang  = clip(ang + rnd(dt * rate, DT_FRAC_BITS));
         dtp  = rnd(dt * p11, DT_FRAC_BITS);
         inner = dtp - p01 - p10 + longint'({32'd0, q_angle});
         p00 = clip(p00 + rnd(dt * inner, DT_FRAC_BITS));
         p01 = clip(p01 - dtp);
         p10 = clip(p10 - dtp);
         p11 = clip(p11 + rnd(longint'({32'd0, q_bias}) * dt, DT_FRAC_BITS));
         y  = clip(meas - ang);
         s  = p00 + longint'({32'd0, r_meas});
         k0 = kgain(p00, s);
         k1 = kgain(p10, s);
         ang = clip(ang + rnd(k0 * y, COV_FRAC_BITS));
         bia = clip(bia + rnd(k1 * y, COV_FRAC_BITS));
         a0 = p00; a1 = p01;
         p00 = clip(p00 - rnd(k0 * a0, COV_FRAC_BITS));
         p01 = clip(p01 - rnd(k0 * a1, COV_FRAC_BITS));
         p10 = clip(p10 - rnd(k1 * a0, COV_FRAC_BITS));
         p11 = clip(p11 - rnd(k1 * a1, COV_FRAC_BITS));
         e.filtered_angle = ang[31:0];
         e.bias_estimate  = bia[31:0];
         e.unbiased_rate  = rate[31:0];
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.filtered_angle !== e.filtered_angle) begin
            $display("%0t: filtered_angle expected %h actual %h", $time,
                     e.filtered_angle, got.filtered_angle);
            errors++;
         end
         if (got.bias_estimate !== e.bias_estimate) begin
            $display("%0t: bias_estimate expected %h actual %h", $time,
                     e.bias_estimate, got.bias_estimate);
            errors++;
         end
         if (got.unbiased_rate !== e.unbiased_rate) begin
            $display("%0t: unbiased_rate expected %h actual %h", $time,
                     e.unbiased_rate, got.unbiased_rate);
            errors++;
         end
      endfunction
   endclass

   filter_scoreboard sb;
   bit no_idle;      // long stretch without idling on either side
   int idle_cycles;  // cycles since anything was accepted

   kalman_angle_bias_filter_top uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random, except in the quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Sample results and count idle cycles for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_psel)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     sb.pending.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Send one beat: random gap first, then hold until accepted.
   // Valid stays up after the beat; a gap in the next call or a pause drops it.
   task automatic send_beat(req_type r);
      if (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // APB write: setup then access; pready is always high.
   task automatic csr_write(int idx, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_noise(idx, v);
      @(posedge clock);
   endtask

   task automatic csr_check(int idx, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      #1;
      if (csr_prdata !== v) begin
         $display("%0t: register %0d expected %h actual %h", $time, idx, v, csr_prdata);
         sb.errors++;
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_noise_all(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm);
      drain();
      csr_write(CSR_ANGLE_NOISE, qa);
      csr_write(CSR_BIAS_NOISE, qb);
      csr_write(CSR_MEAS_NOISE, rm);
      csr_check(CSR_ANGLE_NOISE, qa);
      csr_check(CSR_BIAS_NOISE, qb);
      csr_check(CSR_MEAS_NOISE, rm);
   endtask

   function automatic req_type mk(int a, int g, int d);
      req_type r;
      r.measured_angle = a;
      r.gyro_rate      = g;
      r.time_step      = d[15:0];
      return r;
   endfunction

   // Mostly plausible IMU samples, sometimes full-range noise or field extremes.
   function automatic req_type rand_beat();
      req_type r;
      int kind;
      kind = $urandom_range(9);
      if (kind < 7) begin
         r.measured_angle = $signed($urandom_range(11796480)) - 5898240;
         r.gyro_rate      = $signed($urandom_range(32768000)) - 16384000;
         r.time_step      = 16'($urandom_range(1310, 1));
      end else if (kind < 9) begin
         r.measured_angle = $urandom;
         r.gyro_rate      = $urandom;
         r.time_step      = 16'($urandom);
      end else begin
         r.measured_angle = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         r.gyro_rate      = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         r.time_step      = $urandom_range(1) ? 16'hffff : 16'h0000;
      end
      return r;
   endfunction

   initial begin
      sb = new();
      no_idle     = 1'b0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset.
      csr_check(CSR_ANGLE_NOISE, ANGLE_NOISE_RST);
      csr_check(CSR_BIAS_NOISE, BIAS_NOISE_RST);
      csr_check(CSR_MEAS_NOISE, MEAS_NOISE_RST);

      // Zero innovation variance: all noise zero, zero time step keeps P at zero.
      set_noise_all(32'd0, 32'd0, 32'd0);
      send_beat(mk(32'h00010000, 32'h00020000, 0));
      send_beat(mk(-32'sd65536, 32'h7fffffff, 0));
      // Extremes of the fields, saturating angle and huge innovation.
      set_noise_all(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
      send_beat(mk(32'h7fffffff, 32'h7fffffff, 16'hffff));
      send_beat(mk(32'h80000000, 32'h80000000, 16'hffff));
      send_beat(mk(32'h7fffffff, 32'h80000000, 16'hffff));
      send_beat(mk(32'h80000000, 32'h7fffffff, 0));
      send_beat(mk(0, 0, 1));
      send_beat(mk(32'hffffffff, 32'hffffffff, 16'h8000));
      // Tiny measurement noise with big process noise: gains near and above one.
      set_noise_all(32'hffffffff, 32'hffffffff, 32'd1);
      for (int i = 0; i < 8; i++) send_beat(rand_beat());
      send_beat(mk(32'h7fffffff, 32'h80000000, 16'hffff));
      send_beat(mk(32'h80000000, 32'h7fffffff, 16'hffff));
      set_noise_all(32'd0, 32'hffffffff, 32'hffffffff);
      for (int i = 0; i < 6; i++) send_beat(rand_beat());

      // Random part in phases, each with its own noise setting.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_noise_all(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
            1: set_noise_all($urandom, $urandom, $urandom);
            2: set_noise_all(32'hffffffff, 32'hffffffff, 32'hffffffff);
            3: set_noise_all(32'd0, 32'd0, 32'd0);
            4: set_noise_all($urandom_range(65535), $urandom_range(65535),
                             $urandom_range(1048575));
            default: set_noise_all($urandom, $urandom, 32'd1);
         endcase
         no_idle = (ph == 2);
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            send_beat(rand_beat());
            // Hold the sender until every result is back, once in phase 1.
            if (ph == 1 && i == 100) begin
               req_valid <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
      end
      no_idle = 1'b0;

      drain();
      $display("Covered %0d result beats across several noise settings,", sb.checked);
      $display("including field extremes, saturation and zero innovation variance.");
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
